// ----- hdl/irpd_pkg.sv -----
// ----------------------------------------------------------------------------
// irpd_pkg: shared definitions of the IR pulse-distance command decoder
// Widths, limits, register indexes and reset values used by every file.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int TICK_WIDTH    = 24;
  localparam int MAX_EDGES     = 50;
  localparam int EDGE_W        = $clog2(MAX_EDGES + 1);
  localparam int FIRST_BIT_GAP = 17;
  localparam int CMD_BITS      = 8;
  localparam int POS_W         = $clog2(CMD_BITS);
  localparam int REG_W         = 24;
  localparam int CFG_IDX_W     = 3;

  localparam logic [REG_W-1:0] START_GAP_MIN_RST = REG_W'(10000);
  localparam logic [REG_W-1:0] START_GAP_MAX_RST = REG_W'(14000);
  localparam logic [REG_W-1:0] ONE_GAP_MIN_RST   = REG_W'(2000);
  localparam logic [REG_W-1:0] ONE_GAP_MAX_RST   = REG_W'(2300);
  localparam logic [REG_W-1:0] FRAME_TIMEOUT_RST = REG_W'(1000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_GAP_MIN = 3'd0,
    REG_START_GAP_MAX = 3'd1,
    REG_ONE_GAP_MIN   = 3'd2,
    REG_ONE_GAP_MAX   = 3'd3,
    REG_FRAME_TIMEOUT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] start_gap_min;
    logic [REG_W-1:0] start_gap_max;
    logic [REG_W-1:0] one_gap_min;
    logic [REG_W-1:0] one_gap_max;
    logic [REG_W-1:0] frame_timeout;
  } cfg_t;

endpackage

// ----- hdl/irpd_if.sv -----
// ----------------------------------------------------------------------------
// irpd_if: stream interfaces of the IR pulse-distance command decoder
// One interface for the tick channel and one for the command channel.
// ----------------------------------------------------------------------------
interface irpd_in_if;
  logic valid;
  logic ready;
  logic falling_edge;

  modport source (output valid, output falling_edge, input ready);
  modport sink   (input valid, input falling_edge, output ready);
endinterface

interface irpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [irpd_pkg::CMD_BITS-1:0] command_byte;
  logic                         frame_ok;

  modport source (output valid, output command_byte, output frame_ok, input ready);
  modport sink   (input valid, input command_byte, input frame_ok, output ready);
endinterface

// ----- hdl/irpd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// irpd_cfg_regs: configuration register file
// Holds the gap windows and the frame timeout, written through a plain port.
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [irpd_pkg::REG_W-1:0]     cfg_data,
  output irpd_pkg::cfg_t                 cfg
);

  irpd_pkg::cfg_t cfg_r;
  irpd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        irpd_pkg::REG_START_GAP_MIN: cfg_nxt.start_gap_min = cfg_data;
        irpd_pkg::REG_START_GAP_MAX: cfg_nxt.start_gap_max = cfg_data;
        irpd_pkg::REG_ONE_GAP_MIN:   cfg_nxt.one_gap_min   = cfg_data;
        irpd_pkg::REG_ONE_GAP_MAX:   cfg_nxt.one_gap_max   = cfg_data;
        irpd_pkg::REG_FRAME_TIMEOUT: cfg_nxt.frame_timeout = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_gap_min <= irpd_pkg::START_GAP_MIN_RST;
      cfg_r.start_gap_max <= irpd_pkg::START_GAP_MAX_RST;
      cfg_r.one_gap_min   <= irpd_pkg::ONE_GAP_MIN_RST;
      cfg_r.one_gap_max   <= irpd_pkg::ONE_GAP_MAX_RST;
      cfg_r.frame_timeout <= irpd_pkg::FRAME_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/ir_pulse_distance_command_decoder.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder: NEC-style IR remote command decoder
// Measures the gaps between falling edges of the IR line and emits the
// command byte of each frame once the line has been quiet for a timeout.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake    Payload
//   in_ch     sink       valid/ready  falling_edge (one transaction per tick)
//   out_ch    source     valid/ready  command_byte[7:0], frame_ok
//   cfg_*     sink       cfg_we       cfg_idx[2:0], cfg_data[23:0]
//
// Every tick transaction is taken into an input register and is evaluated
// from there by a single pass of compare and count logic, so one transaction
// is accepted in every cycle while the result register is free or being
// drained. A frame result appears in the result register in the cycle after
// its tick is evaluated. Reset is synchronous and clears the frame
// state and both valid flags; the configuration returns to its defaults.
// When out_ch is stalled with a result waiting, the input register still
// takes one further transaction and then holds it until the result leaves.
// ----------------------------------------------------------------------------
module ir_pulse_distance_command_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  irpd_in_if.sink                        in_ch,
  irpd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [irpd_pkg::REG_W-1:0]     cfg_data
);

  localparam logic [irpd_pkg::TICK_WIDTH-1:0] TICK_MAX = '1;
  localparam logic [irpd_pkg::EDGE_W-1:0] EDGE_LIMIT =
    irpd_pkg::EDGE_W'(irpd_pkg::MAX_EDGES);
  localparam logic [irpd_pkg::EDGE_W-1:0] BIT_FIRST =
    irpd_pkg::EDGE_W'(irpd_pkg::FIRST_BIT_GAP);
  localparam logic [irpd_pkg::EDGE_W-1:0] BIT_END =
    irpd_pkg::EDGE_W'(irpd_pkg::FIRST_BIT_GAP + irpd_pkg::CMD_BITS);

  irpd_pkg::cfg_t cfg;

  irpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Input register: one tick transaction waiting to be evaluated.
  logic in_vld_r;
  logic edge_r;
  logic advance;

  // Frame state.
  logic                                armed_r,     armed_nxt;
  logic [irpd_pkg::TICK_WIDTH-1:0]     ticks_r,     ticks_nxt;
  logic [irpd_pkg::EDGE_W-1:0]         edge_idx_r,  edge_idx_nxt;
  logic [irpd_pkg::TICK_WIDTH-1:0]     start_gap_r, start_gap_nxt;
  logic [irpd_pkg::CMD_BITS-1:0]       bits_r,      bits_nxt;

  // Result register.
  logic                                out_vld_r,   out_vld_nxt;
  logic [irpd_pkg::CMD_BITS-1:0]       cmd_r,       cmd_nxt;
  logic                                ok_r,        ok_nxt;

  logic [irpd_pkg::TICK_WIDTH-1:0]     tick_inc;
  logic [irpd_pkg::EDGE_W-1:0]         idx_off;
  logic [irpd_pkg::POS_W-1:0]          bit_pos;
  logic                                in_bit_range;
  logic                                one_gap;
  logic                                start_ok;
  logic                                frame_end;
  logic                                emit;

  // The tick in the input register is evaluated once the result register can
  // take whatever it produces.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      edge_r <= in_ch.falling_edge;
    end
  end

  // The tick count of the current tick, saturating at the counter maximum.
  assign tick_inc = (ticks_r != TICK_MAX) ? ticks_r + 1'b1 : ticks_r;

  // Gaps 17 to 24 carry the command bits, least significant bit first.
  assign idx_off      = edge_idx_r - BIT_FIRST;
  assign bit_pos      = idx_off[irpd_pkg::POS_W-1:0];
  assign in_bit_range = (edge_idx_r >= BIT_FIRST) && (edge_idx_r < BIT_END);
  assign one_gap      = (tick_inc >= cfg.one_gap_min) && (tick_inc <= cfg.one_gap_max);
  assign start_ok     = (start_gap_r >= cfg.start_gap_min) &&
                        (start_gap_r <= cfg.start_gap_max);

  // A quiet line ends the frame; a saturated count ends it as well, and a
  // zero timeout behaves as a timeout of one tick.
  assign frame_end = (tick_inc >= cfg.frame_timeout) || (tick_inc == TICK_MAX);
  assign emit      = advance && armed_r && !edge_r && frame_end;

  always_comb begin
    armed_nxt     = armed_r;
    ticks_nxt     = ticks_r;
    edge_idx_nxt  = edge_idx_r;
    start_gap_nxt = start_gap_r;
    bits_nxt      = bits_r;
    if (advance) begin
      if (!armed_r) begin
        if (edge_r) begin
          armed_nxt = 1'b1;
          ticks_nxt = '0;
        end
      end else if (edge_r) begin
        // An edge takes priority over a timeout in the same tick.
        if (edge_idx_r < EDGE_LIMIT) begin
          if (edge_idx_r == '0) begin
            start_gap_nxt = tick_inc;
          end else if (in_bit_range) begin
            bits_nxt[bit_pos] = one_gap;
          end
          edge_idx_nxt = edge_idx_r + 1'b1;
        end
        ticks_nxt = '0;
      end else if (frame_end) begin
        // Command bits are kept, so a short repeat frame re-emits them.
        armed_nxt     = 1'b0;
        ticks_nxt     = '0;
        start_gap_nxt = '0;
        edge_idx_nxt  = '0;
      end else begin
        ticks_nxt = tick_inc;
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    cmd_nxt     = cmd_r;
    ok_nxt      = ok_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
      cmd_nxt     = start_ok ? bits_r : '0;
      ok_nxt      = start_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      ticks_r     <= '0;
      edge_idx_r  <= '0;
      start_gap_r <= '0;
      bits_r      <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      ticks_r     <= ticks_nxt;
      edge_idx_r  <= edge_idx_nxt;
      start_gap_r <= start_gap_nxt;
      bits_r      <= bits_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ok_r  <= ok_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.command_byte = cmd_r;
  assign out_ch.frame_ok     = ok_r;

  // The edge index never passes its saturation point.
  a_edge_idx_limit: assert property (@(posedge clk) disable iff (!rst_n)
    edge_idx_r <= EDGE_LIMIT)
    else $error("edge index beyond its limit");

  // A disarmed decoder holds no partial frame.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (ticks_r == '0) && (edge_idx_r == '0) && (start_gap_r == '0))
    else $error("frame state left over while disarmed");

  // Emitting a frame disarms the decoder and presents the result.
  a_emit_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !armed_r && out_vld_r)
    else $error("frame end did not disarm or present a result");

  // A frame with a bad start gap carries an empty command.
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !ok_r) |-> (cmd_r == '0))
    else $error("rejected frame carries command bits");

endmodule

// ----- tb/sv/ir_pulse_distance_command_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_tb: self-checking bench of the IR decoder
// Feeds timer tick transactions, with and without a falling edge, in short
// directed frames and then in random NEC-like frames under several register
// settings. An internal decoder predicts every command result, and each
// result leaving the block is checked field by field against the oldest one
// still due. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module ir_pulse_distance_command_decoder_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam logic [irpd_pkg::REG_W-1:0] REG_MAX = '1;
  localparam int TARGET_TICKS = 600;
  // Phase 0 and the four phases that visit the extreme settings.
  localparam int MIN_PHASES   = 5;

  // Shapes of the tick sequences that the generator builds.
  typedef enum int {
    FRAME_FULL,
    FRAME_REPEAT,
    FRAME_LONG,
    FRAME_BROKEN,
    FRAME_NOISE
  } frame_kind_t;

  // Families of register settings used by the random phases.
  typedef enum int {
    SET_NORMAL,
    SET_WIDE,
    SET_EMPTY,
    SET_TOP,
    SET_TINY
  } settings_mode_t;

  typedef struct packed {
    logic [irpd_pkg::CMD_BITS-1:0] command_byte;
    logic                          frame_ok;
  } cmd_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [irpd_pkg::REG_W-1:0]     cfg_data;

  irpd_in_if  tick_ch ();
  irpd_out_if cmd_ch ();

  ir_pulse_distance_command_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (tick_ch),
    .out_ch   (cmd_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Ticks waiting to be offered, and command results that the decoder model
  // says are still to come out of the block.
  bit          tick_backlog[$];
  cmd_result_t due_cmds[$];

  // Register copy and frame state of the decoder model.
  irpd_pkg::cfg_t                  live_cfg;
  logic                            dec_armed     = 1'b0;
  logic [irpd_pkg::TICK_WIDTH-1:0] dec_ticks     = '0;
  int unsigned                     dec_edge_idx  = 0;
  logic [irpd_pkg::REG_W-1:0]      dec_start_gap = '0;
  logic [irpd_pkg::CMD_BITS-1:0]   dec_bits      = '0;

  // Idling control: per-cycle chance in percent of starting a burst.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned src_gap_left = 0;
  int unsigned snk_stall_left = 0;
  bit          tick_taken = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned frames_decoded = 0;
  int unsigned gen_ticks = 0;
  int unsigned settings_applied = 0;

  // --------------------------------------------------------------------------
  // Decoder model. One call per accepted tick transaction; a frame result is
  // queued when an armed decoder has been quiet for the timeout.
  // --------------------------------------------------------------------------
  task automatic decode_tick(input logic edge_seen);
    cmd_result_t res;
    logic        ok;
    if (!dec_armed) begin
      // The first edge only arms the decoder; quiet ticks are ignored.
      if (edge_seen) begin
        dec_armed = 1'b1;
        dec_ticks = '0;
      end
    end else begin
      if (dec_ticks != '1) dec_ticks++;
      if (edge_seen) begin
        // An edge always wins over a timeout in the same tick.
        if (dec_edge_idx < irpd_pkg::MAX_EDGES) begin
          if (dec_edge_idx == 0) begin
            dec_start_gap = dec_ticks;
          end else if (dec_edge_idx >= irpd_pkg::FIRST_BIT_GAP &&
                       dec_edge_idx < irpd_pkg::FIRST_BIT_GAP + irpd_pkg::CMD_BITS) begin
            dec_bits[dec_edge_idx - irpd_pkg::FIRST_BIT_GAP] =
              (dec_ticks >= live_cfg.one_gap_min) && (dec_ticks <= live_cfg.one_gap_max);
          end
          dec_edge_idx++;
        end
        dec_ticks = '0;
      end else if (dec_ticks >= live_cfg.frame_timeout || dec_ticks == '1) begin
        // Frame end. Bits not refreshed in this frame keep their old values.
        ok = (dec_start_gap >= live_cfg.start_gap_min) &&
             (dec_start_gap <= live_cfg.start_gap_max);
        res.frame_ok     = ok;
        res.command_byte = ok ? dec_bits : '0;
        due_cmds.push_back(res);
        frames_decoded++;
        dec_armed     = 1'b0;
        dec_ticks     = '0;
        dec_start_gap = '0;
        dec_edge_idx  = 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The result check comes
  // first, since a tick accepted at this edge cannot have a result out yet.
  // It also keeps the cycle budget of the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_monitor
    cmd_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_cmds.size());
      $display("tb: failure");
      $finish;
    end else begin
      tick_taken = 1'b0;
      if (rst_n) begin
        if (cmd_ch.valid && cmd_ch.ready) begin
          results_checked++;
          if (due_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("unexpected command result at cycle %0d: byte %02h, ok %b",
                       cycle_count, cmd_ch.command_byte, cmd_ch.frame_ok);
          end else begin
            want = due_cmds.pop_front();
            if (cmd_ch.command_byte !== want.command_byte) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("command_byte mismatch at cycle %0d: expected %02h, got %02h",
                         cycle_count, want.command_byte, cmd_ch.command_byte);
            end
            if (cmd_ch.frame_ok !== want.frame_ok) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("frame_ok mismatch at cycle %0d: expected %b, got %b",
                         cycle_count, want.frame_ok, cmd_ch.frame_ok);
            end
          end
        end
        if (tick_ch.valid && tick_ch.ready) begin
          tick_taken = 1'b1;
          ticks_accepted++;
          decode_tick(tick_ch.falling_edge);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tick driver: offers the backlog one transaction at a time at the falling
  // edge, with random idle bursts between transactions.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : tick_driver
    logic nxt_valid;
    logic nxt_edge;
    nxt_valid = tick_ch.valid;
    nxt_edge  = tick_ch.falling_edge;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      nxt_edge  = 1'b0;
    end else if (!tick_ch.valid || tick_taken) begin
      nxt_valid = 1'b0;
      if (src_gap_left != 0) begin
        src_gap_left--;
      end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        // This cycle is the first of an idle burst.
        src_gap_left = $urandom_range(16, 0);
      end else if (tick_backlog.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_edge  = tick_backlog.pop_front();
      end
    end
    tick_ch.valid        <= nxt_valid;
    tick_ch.falling_edge <= nxt_edge;
  end

  // Result side back-pressure, in bursts drawn like the idle bursts of the tick driver.
  always @(negedge clk) begin : cmd_ready_driver
    if (snk_stall_left != 0) begin
      snk_stall_left--;
      cmd_ch.ready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
      snk_stall_left = $urandom_range(16, 0);
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [irpd_pkg::REG_W-1:0] reg_val(input int unsigned v);
    return irpd_pkg::REG_W'(v);
  endfunction

  task automatic push_tick(input bit edge_seen);
    tick_backlog.push_back(edge_seen);
    gen_ticks++;
  endtask

  task automatic push_quiet(input int unsigned n);
    repeat (n) push_tick(1'b0);
  endtask

  // A gap of n ticks: n-1 quiet ticks and the edge that closes it.
  task automatic push_gap(input int unsigned n);
    push_quiet(n - 1);
    push_tick(1'b1);
  endtask

  // Quiet ticks needed to end a frame; a zero timeout behaves as one tick.
  function automatic int unsigned timeout_ticks();
    return (live_cfg.frame_timeout == 0) ? 1 : live_cfg.frame_timeout;
  endfunction

  function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi,
                                          input int unsigned cap);
    int unsigned a;
    int unsigned b;
    a = (lo < 1) ? 1 : lo;
    b = (hi > cap) ? cap : hi;
    if (a > b) return $urandom_range(cap, 1);
    return $urandom_range(b, a);
  endfunction

  // A gap below the cap, redrawn up to eight times while it lies in the one-window.
  function automatic int unsigned pick_zero_gap(input int unsigned cap);
    int unsigned g;
    g = $urandom_range(cap, 1);
    for (int k = 0; k < 8 && g >= live_cfg.one_gap_min && g <= live_cfg.one_gap_max; k++)
      g = $urandom_range(cap, 1);
    return g;
  endfunction

  function automatic int unsigned idle_choice();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 10;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  // Waits until the backlog is offered and every due result has come out,
  // then lets the pipeline settle before any register is touched.
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_backlog.size() != 0 || tick_ch.valid || due_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input irpd_pkg::reg_idx_t idx,
                           input logic [irpd_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    // No tick is in flight here, so the model copy may change at once.
    case (idx)
      irpd_pkg::REG_START_GAP_MIN: live_cfg.start_gap_min = val;
      irpd_pkg::REG_START_GAP_MAX: live_cfg.start_gap_max = val;
      irpd_pkg::REG_ONE_GAP_MIN:   live_cfg.one_gap_min   = val;
      irpd_pkg::REG_ONE_GAP_MAX:   live_cfg.one_gap_max   = val;
      irpd_pkg::REG_FRAME_TIMEOUT: live_cfg.frame_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [irpd_pkg::REG_W-1:0] smin,
                                input logic [irpd_pkg::REG_W-1:0] smax,
                                input logic [irpd_pkg::REG_W-1:0] omin,
                                input logic [irpd_pkg::REG_W-1:0] omax,
                                input logic [irpd_pkg::REG_W-1:0] tout);
    write_reg(irpd_pkg::REG_START_GAP_MIN, smin);
    write_reg(irpd_pkg::REG_START_GAP_MAX, smax);
    write_reg(irpd_pkg::REG_ONE_GAP_MIN, omin);
    write_reg(irpd_pkg::REG_ONE_GAP_MAX, omax);
    write_reg(irpd_pkg::REG_FRAME_TIMEOUT, tout);
    settings_applied++;
  endtask

  // Register settings are scaled down so that a whole frame takes tens of
  // ticks rather than the tens of thousands of a real receiver.
  task automatic choose_settings(input settings_mode_t mode);
    int unsigned omin;
    int unsigned smin;
    int unsigned smax;
    case (mode)
      SET_WIDE:  apply_settings('0, REG_MAX, '0, REG_MAX, reg_val($urandom_range(12, 3)));
      SET_EMPTY: apply_settings(REG_MAX, '0, REG_MAX, '0, reg_val($urandom_range(12, 3)));
      SET_TOP:   apply_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX,
                                reg_val($urandom_range(12, 3)));
      SET_TINY:  apply_settings('0, reg_val(1), reg_val(1), reg_val(1),
                                reg_val($urandom_range(1, 0)));
      default: begin
        omin = $urandom_range(4, 2);
        smin = $urandom_range(9, 6);
        smax = smin + $urandom_range(3, 0);
        apply_settings(reg_val(smin), reg_val(smax), reg_val(omin),
                       reg_val(omin + $urandom_range(2, 0)),
                       reg_val(smax + $urandom_range(6, 1)));
      end
    endcase
  endtask

  // Builds one frame. Gaps never exceed the timeout, so a frame only ends
  // early where noise or a broken sequence lets it.
  task automatic push_frame(input frame_kind_t kind, input bit close);
    int unsigned                   cap;
    logic [irpd_pkg::CMD_BITS-1:0] cmd;
    cap = timeout_ticks();
    if (cap > 40) cap = 40;
    cmd = irpd_pkg::CMD_BITS'($urandom_range(255, 0));
    case (kind)
      FRAME_NOISE: begin
        repeat ($urandom_range(40, 10)) push_tick($urandom_range(2, 0) == 0);
      end
      FRAME_BROKEN: begin
        push_tick(1'b1);
        repeat ($urandom_range(24, 0)) push_gap($urandom_range(cap, 1));
      end
      default: begin
        push_tick(1'b1);
        if ($urandom_range(4, 0) != 0)
          push_gap(pick_in(live_cfg.start_gap_min, live_cfg.start_gap_max, cap));
        else
          push_gap($urandom_range(cap, 1));
        if (kind == FRAME_REPEAT) begin
          // Start gap and one more edge: the old command bits come back.
          push_gap($urandom_range(cap, 1));
        end else begin
          repeat (irpd_pkg::FIRST_BIT_GAP - 1)
            push_gap($urandom_range((cap < 3) ? cap : 3, 1));
          for (int i = 0; i < irpd_pkg::CMD_BITS; i++) begin
            if (cmd[i])
              push_gap(pick_in(live_cfg.one_gap_min, live_cfg.one_gap_max, cap));
            else
              push_gap(pick_zero_gap(cap));
          end
          // A long frame runs past the saturation of the edge index.
          if (kind == FRAME_LONG)
            repeat ($urandom_range(35, 26)) push_gap($urandom_range(cap, 1));
          else
            repeat ($urandom_range(3, 0)) push_gap($urandom_range(cap, 1));
        end
      end
    endcase
    if (close) push_quiet(timeout_ticks() + $urandom_range(2, 0));
  endtask

  function automatic frame_kind_t random_kind();
    case ($urandom_range(9, 0))
      6:       return FRAME_REPEAT;
      7:       return FRAME_LONG;
      8:       return FRAME_BROKEN;
      9:       return FRAME_NOISE;
      default: return FRAME_FULL;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int             phase;
    settings_mode_t mode;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = irpd_pkg::REG_START_GAP_MIN;
    cfg_data               = '0;
    live_cfg.start_gap_min = irpd_pkg::START_GAP_MIN_RST;
    live_cfg.start_gap_max = irpd_pkg::START_GAP_MAX_RST;
    live_cfg.one_gap_min   = irpd_pkg::ONE_GAP_MIN_RST;
    live_cfg.one_gap_max   = irpd_pkg::ONE_GAP_MAX_RST;
    live_cfg.frame_timeout = irpd_pkg::FRAME_TIMEOUT_RST;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First every register at its top value; quiet ticks on an
    // unarmed decoder must produce nothing.
    src_idle_pct = idle_choice();
    snk_idle_pct = idle_choice();
    apply_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    push_quiet(3);
    wait_drained();

    // A zero timeout acts as one tick. A lone edge gives a short frame that
    // is judged on a start gap of zero, which the window [0,0] accepts; a
    // start gap of one is then rejected.
    apply_settings('0, '0, reg_val(1), reg_val(1), '0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    wait_drained();

    // An edge landing on the very tick the timeout is reached keeps the
    // frame alive; the frame then ends on the following quiet ticks.
    apply_settings(reg_val(2), reg_val(2), reg_val(1), reg_val(1), reg_val(2));
    push_tick(1'b1);
    push_gap(2);
    push_gap(2);
    push_quiet(2);
    wait_drained();

    // Random part. The first phase decodes its bits while the timeout is at
    // its top value, and only closes the frame once the timeout and one
    // window have been rewritten. The next four visit the extreme settings.
    gen_ticks = 0;
    phase = 0;
    while (gen_ticks < TARGET_TICKS || phase < MIN_PHASES) begin
      src_idle_pct = idle_choice();
      snk_idle_pct = idle_choice();
      if (phase == 0) begin
        choose_settings(SET_NORMAL);
        write_reg(irpd_pkg::REG_FRAME_TIMEOUT, REG_MAX);
        push_frame(FRAME_FULL, 1'b0);
        wait_drained();
        write_reg(irpd_pkg::REG_ONE_GAP_MIN, reg_val($urandom_range(3, 1)));
        write_reg(irpd_pkg::REG_FRAME_TIMEOUT, reg_val($urandom_range(20, 5)));
        push_quiet(timeout_ticks());
      end else begin
        case (phase)
          1:       mode = SET_WIDE;
          2:       mode = SET_EMPTY;
          3:       mode = SET_TOP;
          4:       mode = SET_TINY;
          default: begin
            case ($urandom_range(9, 0))
              5:       mode = SET_WIDE;
              6:       mode = SET_EMPTY;
              7:       mode = SET_TOP;
              8:       mode = SET_TINY;
              default: mode = SET_NORMAL;
            endcase
          end
        endcase
        choose_settings(mode);
        repeat ($urandom_range(3, 1)) push_frame(random_kind(), 1'b1);
      end
      // Every phase ends with the sender held off until all results are in.
      wait_drained();
      phase++;
    end

    // Closing phase at full rate on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    choose_settings(SET_NORMAL);
    repeat (2) push_frame(FRAME_FULL, 1'b1);
    wait_drained();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("decoder run: %0d tick transactions, %0d of %0d predicted command results checked",
             ticks_accepted, results_checked, frames_decoded);
    $display("decoder run: %0d register settings over %0d phases, %0d mismatches",
             settings_applied, phase + 1, mismatches);
    if (mismatches == 0 && due_cmds.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/irpd_pkg.sv
hdl/irpd_if.sv
hdl/irpd_cfg_regs.sv
hdl/ir_pulse_distance_command_decoder.sv
tb/sv/ir_pulse_distance_command_decoder_tb.sv
